// ===== rtl/tql_pkg.sv =====
// Shared widths, codes and constants for the three-action Q-learning unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tql_pkg;

   localparam int NUM_STATES = 16;
   localparam int STATE_W    = 4;
   localparam int Q_W        = 32;
   localparam int FRAC_W     = 16;
   localparam int RATE_W     = 17;
   localparam int PCT_W      = 7;
   localparam int CMD_W      = 2;
   localparam int ACT_W      = 2;
   localparam int CSR_IDX_W  = 2;

   // shared multiplier: maxQ by discount and error term by rate, product floored by 2^FRAC_W
   localparam int MUL_A_W = Q_W + 2;
   localparam int MUL_B_W = RATE_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int MQ_W    = PROD_W - FRAC_W;

   localparam logic [RATE_W-1:0] ONE_Q16 = RATE_W'(65536);

   localparam logic [PCT_W-1:0] CHOICE_LEFT_LIMIT   = PCT_W'(30);
   localparam logic [PCT_W-1:0] CHOICE_MIDDLE_LIMIT = PCT_W'(63);

   localparam logic [CMD_W-1:0] CMD_GREEDY  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EXPLORE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd2;

   localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_LEFT   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_MIDDLE = 2'd2;
   localparam logic [ACT_W-1:0] ACT_RIGHT  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCOUNT        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPLORE_PERCENT = 2'd2;

   typedef struct packed {
      logic signed [Q_W-1:0] left;
      logic signed [Q_W-1:0] middle;
      logic signed [Q_W-1:0] right;
   } row_type;

endpackage

// ===== rtl/tql_mul.sv =====
// Shared signed multiplier with registered product, floored by 2^FRAC_W.
// Depends on tql_pkg.
`timescale 1ns / 1ps

module tql_mul (
   input  logic                                clock,
   input  logic signed [tql_pkg::MUL_A_W-1:0]  op_a,
   input  logic signed [tql_pkg::MUL_B_W-1:0]  op_b,
   output logic signed [tql_pkg::MQ_W-1:0]     prod_q
);
   import tql_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // dropping the fraction bits of a two's complement value floors it
   assign prod_q = prod_ff[PROD_W-1:FRAC_W];

endmodule

// ===== rtl/tabular_q_learning_three_action_unit.sv =====
// Top level of the three-action Q-learning unit: sequencer, Q-table and CSRs.
// Depends on tql_pkg and tql_mul.
//
//   channel   ports                       handshake
//   request   start, busy, req_*          taken when start & !busy
//   result    rsp_valid, rsp_*            one-cycle strobe, no back-pressure
//   config    csr_wr_en, csr_index, ...   written when csr_wr_en
//
// Greedy and epsilon-greedy picks do one table read, then the compare; an
// update walks ST_MAX, ST_DMUL, ST_ERR, ST_UMUL and ST_WB, set by the single
// table read port and the two passes through the shared multiplier. busy is high meanwhile.
// Synchronous reset clears the CSRs and the row valid bits, so every row
// reads as zero. The receiver cannot stall: each result is shown once.
`timescale 1ns / 1ps

module tabular_q_learning_three_action_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [tql_pkg::CMD_W-1:0]          req_command,
   input  logic [tql_pkg::STATE_W-1:0]        req_state_index,
   input  logic [tql_pkg::STATE_W-1:0]        req_next_state,
   input  logic [tql_pkg::ACT_W-1:0]          req_action_taken,
   input  logic signed [tql_pkg::Q_W-1:0]     req_reward,
   input  logic [tql_pkg::PCT_W-1:0]          req_explore_draw,
   input  logic [tql_pkg::PCT_W-1:0]          req_choice_draw,
   output logic                               rsp_valid,
   output logic [tql_pkg::ACT_W-1:0]          rsp_chosen_action,
   input  logic                               csr_wr_en,
   input  logic [tql_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tql_pkg::RATE_W-1:0]         csr_wr_data
);
   import tql_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PICK,
      ST_MAX,
      ST_DMUL,
      ST_ERR,
      ST_UMUL,
      ST_WB
   } state_type;

   localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

   function automatic logic in_range(input logic [STATE_W-1:0] idx);
      in_range = (32'(idx) < NUM_STATES);
   endfunction

   function automatic logic [ACT_W-1:0] greedy(input row_type r);
      if (r.left >= r.middle && r.left >= r.right) begin
         greedy = ACT_LEFT;
      end else if (r.middle >= r.right) begin
         greedy = ACT_MIDDLE;
      end else begin
         greedy = ACT_RIGHT;
      end
   endfunction

   function automatic logic [ACT_W-1:0] random_move(input logic [PCT_W-1:0] draw);
      if (draw < CHOICE_LEFT_LIMIT) begin
         random_move = ACT_LEFT;
      end else if (draw < CHOICE_MIDDLE_LIMIT) begin
         random_move = ACT_MIDDLE;
      end else begin
         random_move = ACT_RIGHT;
      end
   endfunction

   function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] v);
      clamp_rate = (v > ONE_Q16) ? ONE_Q16 : v;
   endfunction

   state_type                state_ff;
   logic                     rsp_valid_ff;
   logic [ACT_W-1:0]         rsp_action_ff;
   logic [RATE_W-1:0]        lr_ff;
   logic [RATE_W-1:0]        disc_ff;
   logic [PCT_W-1:0]         eps_ff;
   logic [NUM_STATES-1:0]    row_valid_ff;

   logic [STATE_W-1:0]       state_idx_ff;
   logic [ACT_W-1:0]         action_ff;
   logic signed [Q_W-1:0]    reward_ff;
   logic                     explore_ff;
   logic [PCT_W-1:0]         choice_ff;
   logic signed [Q_W-1:0]    mx_ff;
   row_type                  cur_row_ff;
   logic signed [MUL_A_W-1:0] err_ff;

   row_type                  mem [NUM_STATES];
   row_type                  rd_row_ff;
   logic                     rd_hit_ff;
   logic [STATE_W-1:0]       rd_addr;
   row_type                  row_q;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MQ_W-1:0]    mul_q;

   logic signed [Q_W-1:0]    cur_lane;
   logic signed [Q_W-1:0]    row_max_mid;
   logic signed [MQ_W-1:0]   err_sum;
   logic signed [MQ_W-1:0]   new_sum;
   logic signed [Q_W-1:0]    new_val;
   row_type                  wr_row;
   logic                     wr_en;

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_action = rsp_action_ff;

   // table read port
   always_comb begin
      if (state_ff == ST_IDLE && req_command == CMD_UPDATE) begin
         rd_addr = req_next_state;
      end else if (state_ff == ST_IDLE) begin
         rd_addr = req_state_index;
      end else begin
         rd_addr = state_idx_ff;
      end
   end

   assign row_q = rd_hit_ff ? rd_row_ff : '0;

   always_ff @(posedge clock) begin
      rd_row_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[state_idx_ff] <= wr_row;
      end
   end

   // shared multiplier: discount * maxQ, then learning_rate * error
   always_comb begin
      if (state_ff == ST_DMUL) begin
         mul_a = MUL_A_W'(mx_ff);
         mul_b = {1'b0, disc_ff};
      end else begin
         mul_a = err_ff;
         mul_b = {1'b0, lr_ff};
      end
   end

   tql_mul u_mul (
      .clock  (clock),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .prod_q (mul_q)
   );

   always_comb begin
      unique case (action_ff)
         ACT_LEFT:   cur_lane = cur_row_ff.left;
         ACT_MIDDLE: cur_lane = cur_row_ff.middle;
         ACT_RIGHT:  cur_lane = cur_row_ff.right;
         default:    cur_lane = '0;
      endcase
   end

   assign row_max_mid = (row_q.middle > row_q.left) ? row_q.middle : row_q.left;
   assign err_sum     = MQ_W'(reward_ff) + mul_q - MQ_W'(cur_lane);
   assign new_sum     = MQ_W'(cur_lane) + mul_q;

   always_comb begin
      priority if (new_sum > MQ_W'(Q_MAX)) begin
         new_val = Q_MAX;
      end else if (new_sum < MQ_W'(Q_MIN)) begin
         new_val = Q_MIN;
      end else begin
         new_val = new_sum[Q_W-1:0];
      end
   end

   always_comb begin
      wr_row = cur_row_ff;
      unique case (action_ff)
         ACT_LEFT:   wr_row.left   = new_val;
         ACT_MIDDLE: wr_row.middle = new_val;
         ACT_RIGHT:  wr_row.right  = new_val;
         default:    wr_row        = cur_row_ff;
      endcase
   end

   assign wr_en = (state_ff == ST_WB) && in_range(state_idx_ff) && (action_ff != ACT_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lr_ff        <= '0;
         disc_ff      <= '0;
         eps_ff       <= '0;
         row_valid_ff <= '0;
         rd_hit_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         rd_hit_ff    <= in_range(rd_addr) && row_valid_ff[rd_addr];

         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_LEARNING_RATE:   lr_ff   <= clamp_rate(csr_wr_data);
               CSR_DISCOUNT:        disc_ff <= clamp_rate(csr_wr_data);
               CSR_EXPLORE_PERCENT: eps_ff  <= csr_wr_data[PCT_W-1:0];
               default:             ;
            endcase
         end

         if (wr_en) begin
            row_valid_ff[state_idx_ff] <= 1'b1;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_idx_ff <= req_state_index;
                  action_ff    <= req_action_taken;
                  reward_ff    <= req_reward;
                  choice_ff    <= req_choice_draw;
                  explore_ff   <= (req_command == CMD_EXPLORE) && (req_explore_draw < eps_ff);
                  unique case (req_command)
                     CMD_GREEDY, CMD_EXPLORE: state_ff <= ST_PICK;
                     CMD_UPDATE:              state_ff <= ST_MAX;
                     default:                 state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_PICK: begin
               rsp_valid_ff  <= 1'b1;
               rsp_action_ff <= explore_ff ? random_move(choice_ff) : greedy(row_q);
               state_ff      <= ST_IDLE;
            end
            ST_MAX: begin
               mx_ff    <= (row_q.right > row_max_mid) ? row_q.right : row_max_mid;
               state_ff <= ST_DMUL;
            end
            ST_DMUL: begin
               cur_row_ff <= row_q;
               state_ff   <= ST_ERR;
            end
            ST_ERR: begin
               err_ff   <= err_sum[MUL_A_W-1:0];
               state_ff <= ST_UMUL;
            end
            ST_UMUL: begin
               state_ff <= ST_WB;
            end
            ST_WB: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for tabular_q_learning_three_action_unit: queued requests, own Q-table
// predictor of picks and updates, one-cycle result strobe checked in order.
// Depends on tql_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module testbench;
   import tql_pkg::*;

   localparam logic [CMD_W-1:0]     CMD_UNUSED  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 2'd3;
   localparam int                   IDLE_SETTLE = 12;
   localparam int                   CYCLE_LIMIT = 400000;

   typedef struct {
      logic [CMD_W-1:0]        command;
      logic [STATE_W-1:0]      state_index;
      logic [STATE_W-1:0]      next_state;
      logic [ACT_W-1:0]        action_taken;
      logic signed [Q_W-1:0]   reward;
      logic [PCT_W-1:0]        explore_draw;
      logic [PCT_W-1:0]        choice_draw;
   } request_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [CMD_W-1:0]         req_command = '0;
   logic [STATE_W-1:0]       req_state_index = '0;
   logic [STATE_W-1:0]       req_next_state = '0;
   logic [ACT_W-1:0]         req_action_taken = '0;
   logic signed [Q_W-1:0]    req_reward = '0;
   logic [PCT_W-1:0]         req_explore_draw = '0;
   logic [PCT_W-1:0]         req_choice_draw = '0;
   logic                     rsp_valid;
   logic [ACT_W-1:0]         rsp_chosen_action;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [RATE_W-1:0]        csr_wr_data = '0;

   request_type              pending_requests[$];
   logic [ACT_W-1:0]         expected_actions[$];
   int                       fail_count = 0;
   int                       cycle_count = 0;
   int                       burst_left = 0;
   int                       gap_left = 0;

   // predictor copy of the table and the CSRs
   logic signed [Q_W-1:0]    q_left_tab   [NUM_STATES];
   logic signed [Q_W-1:0]    q_middle_tab [NUM_STATES];
   logic signed [Q_W-1:0]    q_right_tab  [NUM_STATES];
   logic [RATE_W-1:0]        learning_rate_reg = '0;
   logic [RATE_W-1:0]        discount_reg = '0;
   logic [PCT_W-1:0]         explore_pct_reg = '0;

   tabular_q_learning_three_action_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_state_index   (req_state_index),
      .req_next_state    (req_next_state),
      .req_action_taken  (req_action_taken),
      .req_reward        (req_reward),
      .req_explore_draw  (req_explore_draw),
      .req_choice_draw   (req_choice_draw),
      .rsp_valid         (rsp_valid),
      .rsp_chosen_action (rsp_chosen_action),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   always #1 clock = ~clock;

   initial begin
      for (int i = 0; i < NUM_STATES; i++) begin
         q_left_tab[i]   = '0;
         q_middle_tab[i] = '0;
         q_right_tab[i]  = '0;
      end
   end

   function automatic logic [ACT_W-1:0] greedy_action(logic [STATE_W-1:0] s);
      logic signed [Q_W-1:0] l, m, r;
      l = q_left_tab[s];
      m = q_middle_tab[s];
      r = q_right_tab[s];
      if (l >= m && l >= r) return ACT_LEFT;
      if (m >= r) return ACT_MIDDLE;
      return ACT_RIGHT;
   endfunction

   function automatic logic [ACT_W-1:0] explore_action(request_type r);
      if (r.explore_draw < explore_pct_reg) begin
         if (r.choice_draw < CHOICE_LEFT_LIMIT) return ACT_LEFT;
         if (r.choice_draw < CHOICE_MIDDLE_LIMIT) return ACT_MIDDLE;
         return ACT_RIGHT;
      end
      return greedy_action(r.state_index);
   endfunction

   task automatic apply_q_update(request_type r);
      longint mx, cur, dsc, err, upd, nv;
      if (r.action_taken == ACT_NONE) return;
      mx = q_left_tab[r.next_state];
      if (q_middle_tab[r.next_state] > mx) mx = q_middle_tab[r.next_state];
      if (q_right_tab[r.next_state] > mx) mx = q_right_tab[r.next_state];
      case (r.action_taken)
         ACT_LEFT:   cur = q_left_tab[r.state_index];
         ACT_MIDDLE: cur = q_middle_tab[r.state_index];
         default:    cur = q_right_tab[r.state_index];
      endcase
      dsc = (longint'(discount_reg) * mx) >>> FRAC_W;
      err = longint'(r.reward) + dsc - cur;
      upd = (longint'(learning_rate_reg) * err) >>> FRAC_W;
      nv  = cur + upd;
      if (nv > longint'(32'sh7FFF_FFFF)) nv = longint'(32'sh7FFF_FFFF);
      if (nv < longint'(-64'sd2147483648)) nv = -64'sd2147483648;
      case (r.action_taken)
         ACT_LEFT:   q_left_tab[r.state_index]   = Q_W'(nv);
         ACT_MIDDLE: q_middle_tab[r.state_index] = Q_W'(nv);
         default:    q_right_tab[r.state_index]  = Q_W'(nv);
      endcase
   endtask

   task automatic predict_request(request_type r);
      case (r.command)
         CMD_GREEDY:  expected_actions.push_back(greedy_action(r.state_index));
         CMD_EXPLORE: expected_actions.push_back(explore_action(r));
         CMD_UPDATE:  apply_q_update(r);
         default: ;
      endcase
   endtask

   function automatic request_type make_request(logic [CMD_W-1:0] cmd, int s, int ns,
                                                logic [ACT_W-1:0] act,
                                                logic signed [Q_W-1:0] rew,
                                                int ed, int cd);
      request_type r;
      r.command      = cmd;
      r.state_index  = STATE_W'(s);
      r.next_state   = STATE_W'(ns);
      r.action_taken = act;
      r.reward       = rew;
      r.explore_draw = PCT_W'(ed);
      r.choice_draw  = PCT_W'(cd);
      return r;
   endfunction

   function automatic int random_draw();
      if ($urandom_range(0, 4) == 0) return $urandom_range(0, 127);
      return $urandom_range(1, 100);
   endfunction

   function automatic request_type random_request();
      request_type r;
      int          sel;
      sel = $urandom_range(0, 99);
      if (sel < 40)      r.command = CMD_UPDATE;
      else if (sel < 70) r.command = CMD_GREEDY;
      else if (sel < 96) r.command = CMD_EXPLORE;
      else               r.command = CMD_UNUSED;
      r.state_index  = STATE_W'($urandom_range(0, NUM_STATES - 1));
      r.next_state   = STATE_W'($urandom_range(0, NUM_STATES - 1));
      r.action_taken = ($urandom_range(0, 19) == 0) ? ACT_NONE : ACT_W'($urandom_range(1, 3));
      case ($urandom_range(0, 9))
         0:       r.reward = 32'sh7FFF_FFFF;
         1:       r.reward = 32'sh8000_0000;
         2:       r.reward = $urandom;
         default: r.reward = Q_W'(int'($urandom_range(0, 20'hF_FFFF)) - 'h8_0000);
      endcase
      r.explore_draw = PCT_W'(random_draw());
      r.choice_draw  = PCT_W'(random_draw());
      return r;
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      case (idx)
         CSR_LEARNING_RATE:   learning_rate_reg = (val > ONE_Q16) ? ONE_Q16 : val;
         CSR_DISCOUNT:        discount_reg      = (val > ONE_Q16) ? ONE_Q16 : val;
         CSR_EXPLORE_PERCENT: explore_pct_reg   = val[PCT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic end_csr();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pending_requests.size() != 0 || start !== 1'b0 || busy !== 1'b0 ||
             expected_actions.size() != 0)
         @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(int lr, int disc, int pct, int count);
      write_csr(CSR_LEARNING_RATE, RATE_W'(lr));
      write_csr(CSR_DISCOUNT, RATE_W'(disc));
      write_csr(CSR_EXPLORE_PERCENT, RATE_W'(pct));
      end_csr();
      repeat (count) pending_requests.push_back(random_request());
      wait_idle();
   endtask

   // request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin : drive_requests
      request_type seen, nxt;
      if (reset) begin
         start      <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (start && !busy) begin
            seen.command      = req_command;
            seen.state_index  = req_state_index;
            seen.next_state   = req_next_state;
            seen.action_taken = req_action_taken;
            seen.reward       = req_reward;
            seen.explore_draw = req_explore_draw;
            seen.choice_draw  = req_choice_draw;
            predict_request(seen);
         end
         if (start && busy) begin
            // hold the request until taken
         end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            nxt = pending_requests.pop_front();
            req_command      <= nxt.command;
            req_state_index  <= nxt.state_index;
            req_next_state   <= nxt.next_state;
            req_action_taken <= nxt.action_taken;
            req_reward       <= nxt.reward;
            req_explore_draw <= nxt.explore_draw;
            req_choice_draw  <= nxt.choice_draw;
            start            <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 10);
               gap_left   <= $urandom_range(0, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : check_results
      logic [ACT_W-1:0] want;
      if (!reset && rsp_valid) begin
         if (expected_actions.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d",
                     $time, rsp_chosen_action);
            fail_count++;
         end else begin
            want = expected_actions.pop_front();
            if (rsp_chosen_action !== want) begin
               $display("%0t: chosen_action mismatch, expected %0d, actual %0d",
                        $time, want, rsp_chosen_action);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero rates, no exploration
      pending_requests.push_back(make_request(CMD_GREEDY, 0, 0, ACT_LEFT, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_EXPLORE, 7, 0, ACT_LEFT, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_UPDATE, 7, 3, ACT_RIGHT, 32'sh0005_0000,
                                              0, 0));
      pending_requests.push_back(make_request(CMD_GREEDY, 7, 0, ACT_LEFT, 0, 0, 0));
      wait_idle();

      write_csr(CSR_LEARNING_RATE, ONE_Q16);
      write_csr(CSR_DISCOUNT, ONE_Q16);
      write_csr(CSR_EXPLORE_PERCENT, RATE_W'(50));
      end_csr();
      pending_requests.push_back(make_request(CMD_UPDATE, 0, 0, ACT_MIDDLE, 32'sh0005_0000,
                                              0, 0));
      pending_requests.push_back(make_request(CMD_GREEDY, 0, 0, ACT_LEFT, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_UPDATE, 0, 15, ACT_RIGHT, 32'sh7FFF_FFFF,
                                              0, 0));
      // positive saturation
      pending_requests.push_back(make_request(CMD_UPDATE, 0, 0, ACT_RIGHT, 32'sh7FFF_FFFF,
                                              0, 0));
      pending_requests.push_back(make_request(CMD_GREEDY, 0, 0, ACT_LEFT, 0, 0, 0));
      // row 3 at the minimum, then negative saturation through it
      pending_requests.push_back(make_request(CMD_UPDATE, 3, 9, ACT_LEFT, 32'sh8000_0000,
                                              127, 127));
      pending_requests.push_back(make_request(CMD_UPDATE, 3, 9, ACT_MIDDLE, 32'sh8000_0000,
                                              0, 0));
      pending_requests.push_back(make_request(CMD_UPDATE, 3, 9, ACT_RIGHT, 32'sh8000_0000,
                                              0, 0));
      pending_requests.push_back(make_request(CMD_UPDATE, 4, 3, ACT_LEFT, 32'sh8000_0000,
                                              0, 0));
      pending_requests.push_back(make_request(CMD_GREEDY, 4, 0, ACT_LEFT, 0, 0, 0));
      // ties: middle equals right, then all three equal
      pending_requests.push_back(make_request(CMD_UPDATE, 2, 15, ACT_MIDDLE, 32'sh0003_0000,
                                              0, 0));
      pending_requests.push_back(make_request(CMD_UPDATE, 2, 15, ACT_RIGHT, 32'sh0003_0000,
                                              0, 0));
      pending_requests.push_back(make_request(CMD_GREEDY, 2, 0, ACT_LEFT, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_UPDATE, 2, 15, ACT_LEFT, 32'sh0003_0000,
                                              0, 0));
      pending_requests.push_back(make_request(CMD_GREEDY, 2, 0, ACT_LEFT, 0, 0, 0));
      // no action and the unused command leave the table alone
      pending_requests.push_back(make_request(CMD_UPDATE, 5, 0, ACT_NONE, 32'sh7FFF_FFFF,
                                              0, 0));
      pending_requests.push_back(make_request(CMD_UNUSED, 5, 0, ACT_RIGHT, 32'sh7FFF_FFFF,
                                              0, 0));
      pending_requests.push_back(make_request(CMD_GREEDY, 5, 0, ACT_LEFT, 0, 0, 0));
      // exploration limits
      pending_requests.push_back(make_request(CMD_EXPLORE, 0, 0, ACT_LEFT, 0, 49, 29));
      pending_requests.push_back(make_request(CMD_EXPLORE, 0, 0, ACT_LEFT, 0, 0, 30));
      pending_requests.push_back(make_request(CMD_EXPLORE, 0, 0, ACT_LEFT, 0, 10, 62));
      pending_requests.push_back(make_request(CMD_EXPLORE, 0, 0, ACT_LEFT, 0, 10, 63));
      pending_requests.push_back(make_request(CMD_EXPLORE, 4, 0, ACT_LEFT, 0, 50, 0));
      wait_idle();

      run_phase(65536, 58982, 10, 300);
      run_phase(6554, 62259, 30, 250);
      run_phase(131071, 0, 0, 200);
      run_phase(0, 65536, 127, 150);
      run_phase(32768, 131071, 100, 250);
      run_phase($urandom_range(0, 131071), $urandom_range(0, 131071),
                $urandom_range(0, 127), 250);
      write_csr(CSR_UNUSED, RATE_W'($urandom));
      end_csr();
      run_phase(1, 65535, 17'h1_0032, 250);
      run_phase(20000, 45000, 5, 200);

      repeat (IDLE_SETTLE) @(posedge clock);
      if (fail_count == 0 && expected_actions.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
